// ----- rtl/thms_pkg.sv -----
// Shared types and constants for the tuple history match scorer.
// No dependencies.
`default_nettype none
package thms_pkg;

    localparam logic [1:0] OP_APPEND   = 2'd0;
    localparam logic [1:0] OP_KEY      = 2'd1;
    localparam logic [1:0] OP_POST     = 2'd2;
    localparam logic [1:0] OP_RETRIEVE = 2'd3;

    localparam logic [1:0] CFG_TILES    = 2'd0;
    localparam logic [1:0] CFG_WINDOW   = 2'd1;
    localparam logic [1:0] CFG_CLUSTERS = 2'd2;

    localparam int Q_W   = 17;
    localparam int NUM_W = 33;
    localparam logic [Q_W-1:0] Q_ONE = 17'h10000;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [3:0]        tile_index;
        logic signed [7:0] cluster_id;
        logic signed [7:0] temporal_id;
        logic              spatial_use;
        logic              end_of_tuple;
        logic              use_temporal;
        logic              do_fuse;
        logic [6:0]        old_cluster_count;
        logic [5:0]        slot_index;
        logic [16:0]       posterior_value;
    } t_in_word;

    typedef struct packed {
        logic [5:0]        slot_out;
        logic [16:0]       score;
        logic [16:0]       fused_value;
        logic signed [7:0] best_cluster;
        logic              fuse_applied;
        logic              final_result;
    } t_out_word;

    typedef struct packed {
        logic [7:0] spatial;
        logic [7:0] temporal;
        logic       used;
    } t_key;

endpackage
`default_nettype wire

// ----- rtl/thms_hist_ram.sv -----
// History store: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none
module thms_hist_ram #(
    parameter int DEPTH_WORDS = 16384,
    parameter int AW          = 14
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [7:0]    i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [7:0]    o_rdata
);
    logic [7:0] r_mem [DEPTH_WORDS];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// ----- rtl/thms_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Depends on thms_pkg.
`default_nettype none
module thms_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [thms_pkg::NUM_W-1:0]  i_num,
    input  wire logic [thms_pkg::Q_W-1:0]    i_den,
    output logic                             o_done,
    output logic      [thms_pkg::Q_W-1:0]    o_quot
);
    logic [thms_pkg::Q_W:0]       r_rem;
    logic [thms_pkg::NUM_W-1:0]   r_q;
    logic [thms_pkg::Q_W-1:0]     r_den;
    logic [5:0]                   r_cnt;
    logic                         r_busy;
    logic                         r_done;
    logic [thms_pkg::Q_W:0]       rem_sh;
    logic                         take;

    assign rem_sh = {r_rem[thms_pkg::Q_W-1:0], r_q[thms_pkg::NUM_W-1]};
    assign take   = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'(thms_pkg::NUM_W - 1);
                r_rem  <= '0;
                r_q    <= i_num;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem <= take ? rem_sh - {1'b0, r_den} : rem_sh;
                r_q   <= {r_q[thms_pkg::NUM_W-2:0], take};
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 6'd1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q[thms_pkg::Q_W-1:0];
endmodule
`default_nettype wire

// ----- rtl/tuple_history_match_scorer_top.sv -----
// Top level of the tuple history match scorer; uses thms_pkg, thms_hist_ram, thms_div.
// Append, key load and posterior load leave the input ready for the next word.
// Retrieve: per scanned tuple, read its tiles, then the previous tuple's if temporal check
// is on, and count a hit; then per cluster slot: read, divide, multiply, output.
// One word in at a time; results leave through an output register.
// Reset is synchronous: pointers and counts clear, config returns to defaults, stores stay undefined.
`default_nettype none
module tuple_history_match_scorer_top #(
    parameter int MAX_TILES     = 16,
    parameter int CLUSTER_SLOTS = 64,
    parameter int HISTORY_DEPTH = 1024
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire thms_pkg::t_in_word  i_in_word,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output thms_pkg::t_out_word      o_out_word,
    input  wire logic                i_cfg_we,
    input  wire logic [1:0]          i_cfg_index,
    input  wire logic [9:0]          i_cfg_data
);
    localparam int TW     = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
    localparam int MT_W   = TW + 1;
    localparam int DW     = $clog2(HISTORY_DEPTH);
    localparam int CW     = $clog2(CLUSTER_SLOTS);
    localparam int HA_W   = $clog2(HISTORY_DEPTH * MAX_TILES);
    localparam int KC_MAX = (CLUSTER_SLOTS < 64) ? CLUSTER_SLOTS : 64;
    localparam logic [DW-1:0] DEPTH_LAST = DW'(HISTORY_DEPTH - 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CUR    = 4'd1;
    localparam logic [3:0] S_CUR_W  = 4'd2;
    localparam logic [3:0] S_PRV    = 4'd3;
    localparam logic [3:0] S_PRV_W  = 4'd4;
    localparam logic [3:0] S_INC_RD = 4'd5;
    localparam logic [3:0] S_INC_WR = 4'd6;
    localparam logic [3:0] S_NEXT   = 4'd7;
    localparam logic [3:0] S_DEN    = 4'd8;
    localparam logic [3:0] S_K_RD   = 4'd9;
    localparam logic [3:0] S_K_DAT  = 4'd10;
    localparam logic [3:0] S_K_DIV  = 4'd11;
    localparam logic [3:0] S_K_MUL  = 4'd12;
    localparam logic [3:0] S_K_OUT  = 4'd13;

    logic [3:0]           r_state, n_state;
    logic [4:0]           r_tiles;
    logic [9:0]           r_window;
    logic [6:0]           r_clusters;
    logic [DW-1:0]        r_ws;
    logic [31:0]          r_total;
    thms_pkg::t_key       r_key [MAX_TILES];

    logic [3:0]           r_target;
    logic                 r_utemp;
    logic                 r_apply;
    logic signed [7:0]    r_asg;
    logic [6:0]           r_kc;
    logic [MT_W-1:0]      r_mcnt;
    logic [9:0]           r_w;
    logic [9:0]           r_d;
    logic [DW-1:0]        r_cur;
    logic [TW-1:0]        r_m;
    logic                 r_prv_ph;
    logic                 r_tag_vld;
    logic [TW-1:0]        r_tag_m;
    logic                 r_ok;
    logic [7:0]           r_cl;
    logic [9:0]           r_sum;

    logic [CLUSTER_SLOTS-1:0] r_cv;
    logic [9:0]           r_cnt_mem [CLUSTER_SLOTS];
    logic [9:0]           r_cnt_q;
    logic                 r_cnt_qv;
    logic [16:0]          r_post_mem [CLUSTER_SLOTS];
    logic [16:0]          r_post_q;

    logic [16:0]          r_den;
    logic [5:0]           r_k;
    logic signed [7:0]    r_best;
    logic [16:0]          r_best_val;
    logic [16:0]          r_score;
    logic [33:0]          r_prod;
    logic                 r_ovld;
    thms_pkg::t_out_word  r_out;

    logic                 acc;
    logic [6:0]           t7, c7;
    logic [MT_W-1:0]      mcnt_eff;
    logic [6:0]           kc_eff;
    logic [9:0]           wl_c, w_eff;
    logic [DW-1:0]        ws_dec, prv_slot, rd_slot;
    logic [HA_W-1:0]      h_raddr, h_waddr;
    logic                 h_we, h_re;
    logic [7:0]           h_rd;
    thms_pkg::t_key       kd;
    logic                 is_tgt, ok_bit, ok_all;
    logic                 cl_in;
    logic [CW-1:0]        cnt_addr;
    logic [9:0]           cnt_eff;
    logic [16:0]          t_num;
    logic [thms_pkg::NUM_W-1:0] div_num;
    logic                 div_start, div_done;
    logic [16:0]          div_q;
    logic [33:0]          prod_r;
    logic [16:0]          fused;
    logic                 last, out_free, better;
    logic signed [7:0]    new_best;

    assign acc        = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        t7 = (r_tiles == 5'd0) ? 7'd1 : {2'b00, r_tiles};
        if (32'(t7) > MAX_TILES) t7 = 7'(MAX_TILES);
        mcnt_eff = MT_W'(t7);
        c7 = (r_clusters == 7'd0) ? 7'd1 : r_clusters;
        if (32'(c7) > KC_MAX) c7 = 7'(KC_MAX);
        kc_eff = c7;
        wl_c  = (32'(r_window) > HISTORY_DEPTH - 1) ? 10'(HISTORY_DEPTH - 1) : r_window;
        w_eff = (32'(wl_c) > r_total) ? r_total[9:0] : wl_c;
    end

    assign ws_dec   = (r_ws == '0) ? DEPTH_LAST : r_ws - DW'(1);
    assign prv_slot = (r_cur == '0) ? DEPTH_LAST : r_cur - DW'(1);
    assign rd_slot  = r_prv_ph ? prv_slot : r_cur;
    assign h_raddr  = HA_W'(rd_slot) * HA_W'(MAX_TILES) + HA_W'(r_m);
    assign h_waddr  = HA_W'(r_ws) * HA_W'(MAX_TILES) + HA_W'(i_in_word.tile_index);
    assign h_we     = acc && (i_in_word.opcode == thms_pkg::OP_APPEND)
                      && (32'(i_in_word.tile_index) < MAX_TILES);
    assign h_re     = (r_state == S_CUR) || (r_state == S_PRV);

    thms_hist_ram #(
        .DEPTH_WORDS (HISTORY_DEPTH * MAX_TILES),
        .AW          (HA_W)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (h_we),
        .i_waddr (h_waddr),
        .i_wdata (i_in_word.cluster_id),
        .i_re    (h_re),
        .i_raddr (h_raddr),
        .o_rdata (h_rd)
    );

    assign kd     = r_key[r_tag_m];
    assign is_tgt = (7'(r_tag_m) == {3'b000, r_target});
    assign ok_bit = r_prv_ph ? (kd.temporal[7] || (kd.temporal == h_rd))
                             : (!kd.used || is_tgt || (kd.spatial == h_rd));
    assign ok_all = r_ok && (!r_tag_vld || ok_bit);
    assign cl_in  = !r_cl[7] && ({1'b0, r_cl[6:0]} < {1'b0, r_kc});

    assign cnt_addr = (r_state == S_INC_RD) ? CW'(r_cl[6:0]) : CW'(r_k);
    assign cnt_eff  = r_cnt_qv ? r_cnt_q : 10'd0;
    assign t_num    = 17'(17'd100 * 17'(cnt_eff) + 17'd1);
    assign div_num  = (thms_pkg::NUM_W'(t_num) << 16) + thms_pkg::NUM_W'(r_den >> 1);
    assign div_start = (r_state == S_K_DAT);

    thms_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    assign prod_r   = r_prod + 34'd32768;
    assign fused    = r_apply ? prod_r[32:16] : r_post_q;
    assign better   = r_apply && (fused > r_best_val);
    assign new_best = better ? $signed({2'b00, r_k}) : r_best;
    assign last     = ({1'b0, r_k} + 7'd1 == r_kc);
    assign out_free = !r_ovld || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (acc && (i_in_word.opcode == thms_pkg::OP_RETRIEVE)) begin
                    if ((w_eff == 10'd0) || ({3'b000, i_in_word.tile_index} >= 7'(mcnt_eff)))
                        n_state = S_DEN;
                    else
                        n_state = S_CUR;
                end
            end
            S_CUR:    if (r_m == TW'(r_mcnt - MT_W'(1))) n_state = S_CUR_W;
            S_CUR_W: begin
                if (ok_all && r_utemp && (r_total > 32'(r_d))) n_state = S_PRV;
                else if (ok_all) n_state = S_INC_RD;
                else n_state = S_NEXT;
            end
            S_PRV:    if (r_m == TW'(r_mcnt - MT_W'(1))) n_state = S_PRV_W;
            S_PRV_W:  n_state = ok_all ? S_INC_RD : S_NEXT;
            S_INC_RD: n_state = cl_in ? S_INC_WR : S_NEXT;
            S_INC_WR: n_state = S_NEXT;
            S_NEXT:   n_state = (r_d == r_w) ? S_DEN : S_CUR;
            S_DEN:    n_state = S_K_RD;
            S_K_RD:   n_state = S_K_DAT;
            S_K_DAT:  n_state = S_K_DIV;
            S_K_DIV:  if (div_done) n_state = S_K_MUL;
            S_K_MUL:  n_state = S_K_OUT;
            S_K_OUT:  if (out_free) n_state = last ? S_IDLE : S_K_RD;
            default:  n_state = S_IDLE;
        endcase
    end

    // config, pointers and scan control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_tiles    <= 5'd1;
            r_window   <= 10'd1023;
            r_clusters <= 7'd64;
            r_ws       <= '0;
            r_total    <= '0;
            r_tag_vld  <= 1'b0;
            r_cv       <= '0;
            r_ovld     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_tag_vld <= h_re;
            r_tag_m   <= r_m;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    thms_pkg::CFG_TILES:    r_tiles    <= i_cfg_data[4:0];
                    thms_pkg::CFG_WINDOW:   r_window   <= i_cfg_data;
                    thms_pkg::CFG_CLUSTERS: r_clusters <= i_cfg_data[6:0];
                    default: ;
                endcase
            end
            if (r_tag_vld) r_ok <= ok_all;
            if (r_tag_vld && !r_prv_ph && is_tgt) r_cl <= h_rd;
            if (i_out_ready) r_ovld <= 1'b0;

            case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        case (i_in_word.opcode)
                            thms_pkg::OP_APPEND: begin
                                if (i_in_word.end_of_tuple) begin
                                    r_ws <= (r_ws == DEPTH_LAST) ? '0 : r_ws + DW'(1);
                                    if (r_total != 32'hFFFF_FFFF) r_total <= r_total + 32'd1;
                                end
                            end
                            thms_pkg::OP_KEY: begin
                                if (32'(i_in_word.tile_index) < MAX_TILES)
                                    r_key[TW'(i_in_word.tile_index)] <= '{
                                        spatial:  i_in_word.cluster_id,
                                        temporal: i_in_word.temporal_id,
                                        used:     i_in_word.spatial_use};
                            end
                            thms_pkg::OP_RETRIEVE: begin
                                r_target <= i_in_word.tile_index;
                                r_utemp  <= i_in_word.use_temporal;
                                r_apply  <= i_in_word.do_fuse && (i_in_word.cluster_id
                                            < $signed({1'b0, i_in_word.old_cluster_count}));
                                r_asg    <= i_in_word.cluster_id;
                                r_kc     <= kc_eff;
                                r_mcnt   <= mcnt_eff;
                                r_w      <= w_eff;
                                r_d      <= 10'd1;
                                r_cur    <= ws_dec;
                                r_m      <= '0;
                                r_prv_ph <= 1'b0;
                                r_ok     <= 1'b1;
                                r_sum    <= '0;
                                r_cv     <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_CUR, S_PRV: r_m <= r_m + TW'(1);
                S_CUR_W: begin
                    r_m      <= '0;
                    r_ok     <= 1'b1;
                    r_prv_ph <= 1'b1;
                end
                S_INC_WR: begin
                    r_cv[CW'(r_cl[6:0])] <= 1'b1;
                    r_sum <= r_sum + 10'd1;
                end
                S_NEXT: begin
                    r_d      <= r_d + 10'd1;
                    r_cur    <= prv_slot;
                    r_m      <= '0;
                    r_ok     <= 1'b1;
                    r_prv_ph <= 1'b0;
                end
                S_DEN: begin
                    r_den      <= 17'(17'd100 * 17'(r_sum) + 17'(r_kc));
                    r_k        <= '0;
                    r_best     <= r_asg;
                    r_best_val <= '0;
                end
                S_K_DIV: begin
                    if (div_done) begin
                        if (r_total == 32'd0) r_score <= '0;
                        else if (r_sum == 10'd0) r_score <= thms_pkg::Q_ONE;
                        else r_score <= div_q;
                    end
                end
                S_K_MUL: r_prod <= 34'(r_post_q) * 34'(r_score);
                S_K_OUT: begin
                    if (out_free) begin
                        r_ovld <= 1'b1;
                        r_out  <= '{
                            slot_out:     r_k,
                            score:        r_score,
                            fused_value:  fused,
                            best_cluster: last ? new_best : 8'sd0,
                            fuse_applied: r_apply,
                            final_result: last};
                        r_best <= new_best;
                        if (better) r_best_val <= fused;
                        r_k <= r_k + 6'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    // hit count and posterior memories
    always_ff @(posedge i_clk) begin
        r_cnt_q  <= r_cnt_mem[cnt_addr];
        r_cnt_qv <= r_cv[cnt_addr];
        if (r_state == S_INC_WR)
            r_cnt_mem[CW'(r_cl[6:0])] <= cnt_eff + 10'd1;
        r_post_q <= r_post_mem[CW'(r_k)];
        if (acc && (i_in_word.opcode == thms_pkg::OP_POST)
                && (32'(i_in_word.slot_index) < CLUSTER_SLOTS))
            r_post_mem[CW'(i_in_word.slot_index)] <=
                (i_in_word.posterior_value > thms_pkg::Q_ONE) ? thms_pkg::Q_ONE
                                                             : i_in_word.posterior_value;
        else if ((r_state == S_K_OUT) && out_free && r_apply)
            r_post_mem[CW'(r_k)] <= fused;
    end

    assign o_out_valid = r_ovld;
    assign o_out_word  = r_out;
endmodule
`default_nettype wire

// ----- rtl/thms_checker.sv -----
// Port-level checks for the tuple history match scorer, bound to the top level.
// Depends on thms_pkg and tuple_history_match_scorer_top.
`default_nettype none
module thms_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                o_in_ready,
    input wire thms_pkg::t_in_word  i_in_word,
    input wire logic                o_out_valid,
    input wire logic                i_out_ready,
    input wire thms_pkg::t_out_word o_out_word
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("stalled output word changed");

    a_best_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.final_result |-> o_out_word.best_cluster == 8'sd0)
        else $error("best_cluster set on non-final word");

    a_load_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_in_word.opcode != thms_pkg::OP_RETRIEVE)
        |=> o_in_ready)
        else $error("load word did not finish in one cycle");

    a_retr_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_in_word.opcode == thms_pkg::OP_RETRIEVE)
        |=> !o_in_ready)
        else $error("retrieve did not hold off input");
endmodule

bind tuple_history_match_scorer_top thms_checker u_thms_checker (.*);
`default_nettype wire
